// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, skipped while reset is held.
`define GFF_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("flood fill check failed");

// Condition that must never be true.
`define GFF_NEVER(lbl, clk_s, rst_s, cond) \
  `GFF_ASSERT(lbl, clk_s, rst_s, !(cond))

`endif

// File: src/gff_pkg.sv
// ----------------------------------------------------------------------------
// gff_pkg
// Codes and fixed field widths of the grid flood fill block.
// ----------------------------------------------------------------------------
package gff_pkg;

  localparam int OP_W    = 2;
  localparam int COORD_W = 6;
  localparam int VALUE_W = 16;
  localparam int COUNT_W = 13;
  localparam int CFG_W   = 7;
  localparam int DIM_W   = 11;   // holds any row or column count up to 1024

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_FILL  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_OUTSIDE = 1'b1;

endpackage

// File: src/grid_flood_fill.sv
// ----------------------------------------------------------------------------
// grid_flood_fill
// Pixel grid with write, read and 4-connected breadth-first flood fill.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  in_     | in  | in_tvalid/tready   | tuser op, tdata row/col/pixel
//  out_    | out | out_tvalid/tready  | tuser status, tdata value/count
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data (rows, cols)
//
//  Write, unknown op, or outside coordinate: answered from the idle state. Read:
//  via S_READ. Fill: ends in S_OLD when the start pixel already has the new color,
//  else pops each repainted pixel (S_POP, S_POPW), then steps each neighbor in
//  S_NB and compares one on the image in S_CHK, through one shared step unit.
//  Reset is synchronous; the RAMs are not cleared, no sweep after reset.
//  The next request is taken once the finished result has left or leaves.
// ----------------------------------------------------------------------------
module grid_flood_fill #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int PIXEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // row_index[5:0], col_index[11:6], pixel_value[27:12]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  // result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_value[15:0], filled_count[28:16]
  output logic        out_tuser,  // status[0]
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int RW     = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = CELLS > 1 ? $clog2(CELLS) : 1;
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int QW     = RW + CW;
  localparam int DW     = gff_pkg::DIM_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_OLD  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_POPW = 3'd4;
  localparam logic [2:0] S_NB   = 3'd5;
  localparam logic [2:0] S_CHK  = 3'd6;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [RW-1:0] r,
                                                  input logic [CW-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  // control registers
  logic [2:0]              state_r, state_nxt;
  logic [gff_pkg::CFG_W-1:0] rows_r, cols_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              k_r, k_nxt;
  logic [CNT_W-1:0]        head_r, head_nxt;
  logic [CNT_W-1:0]        tail_r, tail_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  // payload registers
  logic [RW-1:0]           cur_row_r, cur_row_nxt;
  logic [CW-1:0]           cur_col_r, cur_col_nxt;
  logic [RW-1:0]           nb_row_r, nb_row_nxt;
  logic [CW-1:0]           nb_col_r, nb_col_nxt;
  logic [ADDR_W-1:0]       nb_addr_r, nb_addr_nxt;
  logic [ADDR_W-1:0]       addr_r, addr_nxt;
  logic [PIXEL_BITS-1:0]   color_r, color_nxt;
  logic [PIXEL_BITS-1:0]   old_r, old_nxt;
  logic [15:0]             res_rd_r, res_rd_nxt;
  logic [gff_pkg::COUNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                    res_st_r, res_st_nxt;

  // RAM ports
  logic                    p_we;
  logic [ADDR_W-1:0]       p_waddr, p_raddr;
  logic [PIXEL_BITS-1:0]   p_wdata, p_rdata;
  logic                    q_we;
  logic [ADDR_W-1:0]       q_waddr, q_raddr;
  logic [QW-1:0]           q_wdata, q_rdata;

  // request decode
  logic [gff_pkg::OP_W-1:0]    in_op;
  logic [gff_pkg::COORD_W-1:0] in_row, in_col;
  logic [gff_pkg::VALUE_W-1:0] in_val;
  logic [DW-1:0]           in_row_w, in_col_w;
  logic [RW-1:0]           in_r;
  logic [CW-1:0]           in_c;
  logic [ADDR_W-1:0]       in_addr;
  logic [PIXEL_BITS+15:0]  in_pix_wide;
  logic [PIXEL_BITS-1:0]   in_pix;
  logic                    in_fire, in_range;
  logic [DW-1:0]           rows_w, cols_w, used_rows, used_cols;

  // neighbor step unit
  logic [DW-1:0]           cr_w, cc_w, nr_w, nc_w;
  logic                    nb_ok;
  logic [ADDR_W-1:0]       nb_addr;

  logic [PIXEL_BITS+15:0]  p_rdata_wide;
  logic [CNT_W+12:0]       cnt_wide;

  assign in_op   = in_tuser;
  assign in_row  = in_tdata[5:0];
  assign in_col  = in_tdata[11:6];
  assign in_val  = in_tdata[27:12];

  assign rows_w    = DW'(rows_r);
  assign cols_w    = DW'(cols_r);
  assign used_rows = (rows_w > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : rows_w;
  assign used_cols = (cols_w > DW'(MAX_COLS)) ? DW'(MAX_COLS) : cols_w;

  assign in_row_w    = DW'(in_row);
  assign in_col_w    = DW'(in_col);
  assign in_r        = in_row_w[RW-1:0];
  assign in_c        = in_col_w[CW-1:0];
  assign in_addr     = cell_addr(in_r, in_c);
  assign in_range    = (in_row_w < used_rows) && (in_col_w < used_cols);
  assign in_pix_wide = {{PIXEL_BITS{1'b0}}, in_val};
  assign in_pix      = in_pix_wide[PIXEL_BITS-1:0];

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign p_rdata_wide = {16'd0, p_rdata};
  assign cnt_wide     = {13'd0, cnt_r};

  // next neighbor of the current cell in the order up, right, down, left
  assign cr_w = DW'(cur_row_r);
  assign cc_w = DW'(cur_col_r);
  always_comb begin
    nr_w  = cr_w;
    nc_w  = cc_w;
    nb_ok = 1'b0;
    unique case (k_r)
      DIR_UP: begin
        nr_w  = cr_w - DW'(1);
        nb_ok = (cr_w != '0);
      end
      DIR_RIGHT: begin
        nc_w  = cc_w + DW'(1);
        nb_ok = (nc_w < used_cols);
      end
      DIR_DOWN: begin
        nr_w  = cr_w + DW'(1);
        nb_ok = (nr_w < used_rows);
      end
      DIR_LEFT: begin
        nc_w  = cc_w - DW'(1);
        nb_ok = (cc_w != '0);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end
  assign nb_addr = cell_addr(nr_w[RW-1:0], nc_w[CW-1:0]);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    k_nxt         = k_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    nb_row_nxt    = nb_row_r;
    nb_col_nxt    = nb_col_r;
    nb_addr_nxt   = nb_addr_r;
    addr_nxt      = addr_r;
    color_nxt     = color_r;
    old_nxt       = old_r;
    res_rd_nxt    = res_rd_r;
    res_cnt_nxt   = res_cnt_r;
    res_st_nxt    = res_st_r;
    p_we          = 1'b0;
    p_waddr       = nb_addr_r;
    p_wdata       = color_r;
    p_raddr       = in_addr;
    q_we          = 1'b0;
    q_waddr       = tail_r[ADDR_W-1:0];
    q_wdata       = {nb_row_r, nb_col_r};
    q_raddr       = head_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cur_row_nxt = in_r;
          cur_col_nxt = in_c;
          addr_nxt    = in_addr;
          color_nxt   = in_pix;
          res_rd_nxt  = '0;
          res_cnt_nxt = '0;
          res_st_nxt  = gff_pkg::ST_OK;
          if (in_op == gff_pkg::OP_WRITE || in_op == gff_pkg::OP_READ ||
              in_op == gff_pkg::OP_FILL) begin
            if (!in_range) begin
              res_st_nxt    = gff_pkg::ST_OUTSIDE;
              out_valid_nxt = 1'b1;
            end else if (in_op == gff_pkg::OP_WRITE) begin
              p_we          = 1'b1;
              p_waddr       = in_addr;
              p_wdata       = in_pix;
              out_valid_nxt = 1'b1;
            end else if (in_op == gff_pkg::OP_READ) begin
              state_nxt = S_READ;
            end else begin
              state_nxt = S_OLD;
            end
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_READ: begin
        res_rd_nxt    = p_rdata_wide[15:0];
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_OLD: begin
        old_nxt = p_rdata;
        if (p_rdata == color_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          p_we      = 1'b1;
          p_waddr   = addr_r;
          q_we      = 1'b1;
          q_waddr   = '0;
          q_wdata   = {cur_row_r, cur_col_r};
          head_nxt  = '0;
          tail_nxt  = CNT_W'(1);
          cnt_nxt   = CNT_W'(1);
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (head_r < tail_r) begin
          head_nxt  = head_r + CNT_W'(1);
          state_nxt = S_POPW;
        end else begin
          res_cnt_nxt   = cnt_wide[12:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_POPW: begin
        cur_row_nxt = q_rdata[QW-1:CW];
        cur_col_nxt = q_rdata[CW-1:0];
        k_nxt       = DIR_UP;
        state_nxt   = S_NB;
      end
      S_NB: begin
        if (nb_ok) begin
          p_raddr     = nb_addr;
          nb_row_nxt  = nr_w[RW-1:0];
          nb_col_nxt  = nc_w[CW-1:0];
          nb_addr_nxt = nb_addr;
          state_nxt   = S_CHK;
        end else if (k_r == DIR_LEFT) begin
          state_nxt = S_POP;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_CHK: begin
        if (p_rdata == old_r) begin
          p_we    = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (tail_r < CNT_W'(CELLS)) begin
            q_we     = 1'b1;
            tail_nxt = tail_r + CNT_W'(1);
          end
        end
        if (k_r == DIR_LEFT) begin
          state_nxt = S_POP;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_NB;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      rows_r      <= gff_pkg::DIM_RESET;
      cols_r      <= gff_pkg::DIM_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gff_pkg::REG_ROWS) begin
          rows_r <= cfg_data;
        end else begin
          cols_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_row_r <= cur_row_nxt;
    cur_col_r <= cur_col_nxt;
    nb_row_r  <= nb_row_nxt;
    nb_col_r  <= nb_col_nxt;
    nb_addr_r <= nb_addr_nxt;
    addr_r    <= addr_nxt;
    color_r   <= color_nxt;
    old_r     <= old_nxt;
    res_rd_r  <= res_rd_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_st_r  <= res_st_nxt;
  end

  gff_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (CELLS)
  ) u_pixel_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  gff_ram #(
    .WIDTH (QW),
    .DEPTH (CELLS)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, res_cnt_r, res_rd_r};
  assign out_tuser  = res_st_r;

endmodule

// File: src/gff_ram.sv
// ----------------------------------------------------------------------------
// gff_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/gff_checker.sv
// ----------------------------------------------------------------------------
// gff_checker
// Port-level checks on the grid flood fill block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gff_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  logic        wr_fire;
  logic        out_stall;
  logic [15:0] res_value;
  logic [12:0] res_count;

  // writes and unknown ops are answered from the idle state with a registered result
  assign wr_fire = in_tvalid && in_tready &&
                   (in_tuser == gff_pkg::OP_WRITE || in_tuser == gff_pkg::OP_NONE);

  assign out_stall = out_tvalid && !out_tready;
  assign res_value = out_tdata[15:0];
  assign res_count = out_tdata[28:16];

  `GFF_ASSERT(a_write_one_cycle, clk, rst_n, wr_fire |=> out_tvalid)

  `GFF_NEVER(a_no_take_on_full_out, clk, rst_n, in_tready && out_stall)

  `GFF_ASSERT(a_outside_is_blank, clk, rst_n, (out_tvalid && out_tuser) |-> (out_tdata == '0))

  `GFF_ASSERT(a_read_or_count, clk, rst_n, out_tvalid |-> (res_value == '0 || res_count == '0))

  `GFF_ASSERT(a_out_hold, clk, rst_n, out_stall |=> (out_tvalid && $stable(out_tdata)))

endmodule

bind grid_flood_fill gff_checker u_gff_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: grid flood fill testbench
// Streams pixel writes, reads, fills and unknown ops through the block under a range of
// image sizes. Every taken request is predicted on a local copy of the grid,
// and each result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int GRID_COLS  = 64;
  localparam int GRID_CELLS = 4096;
  localparam int NUM_PHASES = 13;

  typedef logic [gff_pkg::OP_W-1:0]    op_code_t;
  typedef logic [gff_pkg::COORD_W-1:0] coord_t;
  typedef logic [gff_pkg::VALUE_W-1:0] pix_t;
  typedef logic [gff_pkg::COUNT_W-1:0] count_t;
  typedef logic [gff_pkg::CFG_W-1:0]   dim_t;

  typedef struct packed {
    logic      drain_first;
    op_code_t  op;
    coord_t    row;
    coord_t    col;
    pix_t      pix;
  } pixel_req_t;

  typedef struct packed {
    pix_t      value;
    count_t    count;
    logic      status;
  } pixel_res_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = 1'b0;
  logic [6:0]  cfg_data   = '0;

  grid_flood_fill u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // local image model and its register copies
  pix_t       pixel_grid [GRID_CELLS];
  int         walk_q     [GRID_CELLS];
  dim_t       cfg_rows = gff_pkg::DIM_RESET;
  dim_t       cfg_cols = gff_pkg::DIM_RESET;

  pixel_req_t pending_reqs[$];
  pixel_res_t awaited_results[$];
  pixel_req_t cur_req;
  bit         req_loaded = 0;

  // stimulus bookkeeping: which pixels hold a known value
  bit   written_map [GRID_CELLS];
  int   written_list[$];
  pix_t palette [3];
  int   issued_total = 0;
  int   idle_pct     = 25;
  int   error_count  = 0;
  int   gap_left     = 0;
  int   stall_left   = 0;

  int phase_rows [NUM_PHASES] = '{1, 64, 2, 1, 64, 8, 100, 11, 3, 64, 16, 5, 127};
  int phase_cols [NUM_PHASES] = '{1, 2, 64, 64, 1, 8, 2, 7, 127, 64, 8, 5, 127};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int used_dim(dim_t v);
    return (v > 64) ? 64 : int'(v);
  endfunction

  function automatic pixel_res_t predict_pixel_op(pixel_req_t r);
    pixel_res_t res;
    int         nrows, ncols, idx, head, tail, pos, pr, pc, nr, nc, k, nidx;
    pix_t       old_pix;
    res   = '0;
    nrows = used_dim(cfg_rows);
    ncols = used_dim(cfg_cols);
    if (r.op == gff_pkg::OP_NONE) return res;
    if (r.row >= nrows || r.col >= ncols) begin
      res.status = gff_pkg::ST_OUTSIDE;
      return res;
    end
    idx = r.row * GRID_COLS + r.col;
    if (r.op == gff_pkg::OP_WRITE) begin
      pixel_grid[idx] = r.pix;
    end else if (r.op == gff_pkg::OP_READ) begin
      res.value = pixel_grid[idx];
    end else begin
      old_pix = pixel_grid[idx];
      if (old_pix != r.pix) begin
        // breadth-first walk; a pixel is recolored as it is queued
        pixel_grid[idx] = r.pix;
        walk_q[0] = idx;
        head = 0;
        tail = 1;
        while (head < tail) begin
          pos = walk_q[head];
          head++;
          pr = pos / GRID_COLS;
          pc = pos % GRID_COLS;
          for (k = 0; k < 4; k++) begin
            nr = pr;
            nc = pc;
            case (k)
              0: nr = pr - 1;
              1: nc = pc + 1;
              2: nr = pr + 1;
              default: nc = pc - 1;
            endcase
            if (nr < 0 || nc < 0 || nr >= nrows || nc >= ncols) continue;
            nidx = nr * GRID_COLS + nc;
            if (pixel_grid[nidx] == old_pix) begin
              pixel_grid[nidx] = r.pix;
              walk_q[tail] = nidx;
              tail++;
            end
          end
        end
        res.count = count_t'(tail);
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    if (idle_pct == 0 || $urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request driver
  always @(posedge clk) begin
    logic next_valid;
    logic took;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      took       = in_tvalid && in_tready;
      next_valid = in_tvalid && !took;
      if (took) begin
        awaited_results.push_back(predict_pixel_op(cur_req));
        req_loaded = 0;
        gap_left   = pick_gap();
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain_first && awaited_results.size() != 0)) begin
          cur_req    = pending_reqs.pop_front();
          req_loaded = 1;
          in_tdata   <= {4'b0, cur_req.pix, cur_req.col, cur_req.row};
          in_tuser   <= cur_req.op;
          next_valid = 1'b1;
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // result monitor
  always @(posedge clk) begin
    pixel_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                   $time, out_tdata, out_tuser);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata[15:0] !== want.value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.value,
                     out_tdata[15:0]);
            error_count++;
          end
          if (out_tdata[28:16] !== want.count) begin
            $display("%0t: filled_count expected %0d actual %0d", $time, want.count,
                     out_tdata[28:16]);
            error_count++;
          end
          if (out_tuser !== want.status) begin
            $display("%0t: status expected %b actual %b", $time, want.status, out_tuser);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_tready <= (stall_left == 0);
      end
    end
  end

  function automatic void add_req(op_code_t op, int row, int col, pix_t pix,
                                  bit hold = 0);
    pixel_req_t r;
    int         idx;
    r = '{drain_first: hold, op: op, row: coord_t'(row), col: coord_t'(col), pix: pix};
    pending_reqs.push_back(r);
    issued_total++;
    if (op == gff_pkg::OP_WRITE && row < used_dim(cfg_rows) && col < used_dim(cfg_cols))
    begin
      idx = row * GRID_COLS + col;
      written_map[idx] = 1;
      written_list.push_back(idx);
    end
  endfunction

  function automatic pix_t palette_color();
    if ($urandom_range(4) != 0) return palette[$urandom_range(0, 2)];
    return pix_t'($urandom);
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || req_loaded || awaited_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input dim_t val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == gff_pkg::REG_ROWS) cfg_rows = val;
    else cfg_cols = val;
  endtask

  task automatic run_phase(input int rows_v, input int cols_v, input int n_mixed);
    int   nr, nc, r, c, k, pick, pos;
    bit   fill_ok, hold;
    cfg_write(gff_pkg::REG_ROWS, rows_v[6:0]);
    cfg_write(gff_pkg::REG_COLS, cols_v[6:0]);
    nr      = used_dim(cfg_rows);
    nc      = used_dim(cfg_cols);
    fill_ok = (nr * nc <= 256);
    for (k = 0; k < 3; k++) begin
      pick = $urandom_range(9);
      palette[k] = (pick == 0) ? '0 : (pick == 1) ? '1 : pix_t'($urandom);
    end
    // fills compare every neighbor in the image, so load the whole image first
    if (fill_ok) begin
      for (r = 0; r < nr; r++)
        for (c = 0; c < nc; c++)
          if (!written_map[r * GRID_COLS + c])
            add_req(gff_pkg::OP_WRITE, r, c, palette_color());
    end
    for (k = 0; k < n_mixed; k++) begin
      pick = $urandom_range(99);
      hold = (k == 20) || ($urandom_range(99) == 0);
      r    = $urandom_range(0, nr - 1);
      c    = $urandom_range(0, nc - 1);
      if (!fill_ok) begin
        if (pick < 45) begin
          add_req(gff_pkg::OP_WRITE, r, c, palette_color(), hold);
        end else if (pick < 88 && written_list.size() > 0) begin
          pos = written_list[$urandom_range(0, written_list.size() - 1)];
          if (pos / GRID_COLS < nr && pos % GRID_COLS < nc)
            add_req(gff_pkg::OP_READ, pos / GRID_COLS, pos % GRID_COLS, pix_t'($urandom),
                    hold);
          else
            add_req(gff_pkg::OP_WRITE, r, c, palette_color(), hold);
        end else begin
          add_req(gff_pkg::OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                  pix_t'($urandom), hold);
        end
      end else if (pick < 28) begin
        add_req(gff_pkg::OP_WRITE, r, c, palette_color(), hold);
      end else if (pick < 50) begin
        add_req(gff_pkg::OP_READ, r, c, pix_t'($urandom), hold);
      end else if (pick < 80) begin
        add_req(gff_pkg::OP_FILL, r, c, palette_color(), hold);
      end else if (pick < 93 && (nr < 64 || nc < 64)) begin
        if (nc == 64 || (nr < 64 && $urandom_range(1))) r = $urandom_range(nr, 63);
        else c = $urandom_range(nc, 63);
        add_req(op_code_t'($urandom_range(0, 2)), r, c, pix_t'($urandom), hold);
      end else begin
        add_req(gff_pkg::OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                pix_t'($urandom), hold);
      end
    end
  endtask

  initial begin
    int ph, n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // full 64 x 64 image after reset: corners, reads, unknown operation
    add_req(gff_pkg::OP_WRITE, 0, 0, 16'h0000);
    add_req(gff_pkg::OP_WRITE, 63, 63, 16'hFFFF);
    add_req(gff_pkg::OP_WRITE, 0, 63, 16'h1234);
    add_req(gff_pkg::OP_WRITE, 63, 0, 16'hEDCB);
    add_req(gff_pkg::OP_READ, 63, 63, 16'h0000);
    add_req(gff_pkg::OP_READ, 0, 0, 16'hFFFF);
    add_req(gff_pkg::OP_NONE, 63, 63, 16'hFFFF);
    add_req(gff_pkg::OP_NONE, 0, 0, 16'h0000);

    // 2 x 3 image: fill, same-color fill, outside coordinates
    cfg_write(gff_pkg::REG_ROWS, 7'd2);
    cfg_write(gff_pkg::REG_COLS, 7'd3);
    add_req(gff_pkg::OP_WRITE, 0, 1, 16'h0000);
    add_req(gff_pkg::OP_WRITE, 0, 2, 16'h0007);
    add_req(gff_pkg::OP_WRITE, 1, 0, 16'h0000);
    add_req(gff_pkg::OP_WRITE, 1, 1, 16'h0000);
    add_req(gff_pkg::OP_WRITE, 1, 2, 16'h0007);
    add_req(gff_pkg::OP_FILL, 0, 0, 16'h0009);
    add_req(gff_pkg::OP_FILL, 1, 1, 16'h0009);
    add_req(gff_pkg::OP_FILL, 1, 2, 16'h0009);
    add_req(gff_pkg::OP_FILL, 2, 0, 16'h0001);
    add_req(gff_pkg::OP_READ, 0, 3, 16'h0000);
    add_req(gff_pkg::OP_WRITE, 63, 63, 16'h0000);
    add_req(gff_pkg::OP_READ, 1, 2, 16'h0000);

    // zero rows: empty image
    cfg_write(gff_pkg::REG_ROWS, 7'd0);
    add_req(gff_pkg::OP_READ, 0, 0, 16'h0000);
    add_req(gff_pkg::OP_NONE, 0, 0, 16'h0000);

    // oversized registers saturate; stored pixels stay where they were
    cfg_write(gff_pkg::REG_ROWS, 7'd127);
    cfg_write(gff_pkg::REG_COLS, 7'd127);
    add_req(gff_pkg::OP_READ, 63, 63, 16'h0000);
    add_req(gff_pkg::OP_READ, 0, 63, 16'h0000);

    ph = 0;
    while (issued_total < 610) begin
      idle_pct = (ph % 4 == 3) ? 0 : 30;
      n = $urandom_range(35, 55);
      if (ph < NUM_PHASES) run_phase(phase_rows[ph], phase_cols[ph], n);
      else run_phase($urandom_range(1, 16), $urandom_range(1, 16), n);
      ph++;
    end

    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while ((pending_reqs.size() != 0 || req_loaded || awaited_results.size() != 0)
               && n < 1_000_000);
    if (pending_reqs.size() != 0 || req_loaded || awaited_results.size() != 0) begin
      $display("%0t: %0d requests and %0d results expected, actual none", $time,
               pending_reqs.size() + int'(req_loaded), awaited_results.size());
      error_count++;
    end
    repeat (40) @(posedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/gff_pkg.sv
src/gff_ram.sv
src/grid_flood_fill.sv
src/gff_checker.sv
tb/sv/tb.sv
